@@ rtl/bfra_pkg.sv @@
// Shared types and constants for the best-fit range allocator.
package bfra_pkg;

   // Field widths fixed by the request and response formats.
   localparam int OFF_W = 27;
   localparam int LEN_W = 28;

   // Operation codes.
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Status codes.
   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_NO_FIT = 2'd1;
   localparam logic [1:0] STAT_FULL   = 2'd2;

   typedef struct packed {
      logic             op;
      logic [LEN_W-1:0] req_size;
      logic [OFF_W-1:0] req_offset;
   } req_type;

   typedef struct packed {
      logic [OFF_W-1:0] alloc_offset;
      logic [1:0]       status;
      logic             pool_idle;
   } rsp_type;

   // One free range as held by a cell.
   typedef struct packed {
      logic [OFF_W-1:0] start;
      logic [LEN_W-1:0] length;
   } entry_type;

   // Search token that walks down the chain, one cell per cycle.
   typedef struct packed {
      logic             best_found;
      logic [OFF_W-1:0] best_start;
      logic [LEN_W-1:0] best_len;
      logic             has_prev;
      logic [OFF_W-1:0] prev_start;
      logic [LEN_W-1:0] prev_end;
      logic             stopped;
      logic [OFF_W-1:0] nxt_start;
      logic [LEN_W-1:0] nxt_end;
   } token_type;

   // Table update issued to every cell at once.
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_WRITE,
      CMD_INSERT,
      CMD_DELETE
   } cmd_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MERGE,
      ST_FINISH,
      ST_RESP
   } state_type;

endpackage

@@ rtl/bfra_cell.sv @@
// One slot of the free-range table with its stage of the search token chain.
module bfra_cell
   import bfra_pkg::*;
#(
   parameter int INDEX           = 0,
   parameter int MAX_FREE_RANGES = 64,
   parameter int POOL_SIZE       = 134217728,
   parameter int CNT_W           = $clog2(MAX_FREE_RANGES + 1),
   parameter int IDX_W           = $clog2(MAX_FREE_RANGES)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [CNT_W-1:0] count,
   input  logic [LEN_W-1:0] size,
   input  logic [OFF_W-1:0] offset,
   input  token_type        tok_in,
   input  logic [IDX_W-1:0] best_idx_in,
   input  logic [CNT_W-1:0] pos_in,
   output token_type        tok_out,
   output logic [IDX_W-1:0] best_idx_out,
   output logic [CNT_W-1:0] pos_out,
   input  entry_type        left_entry,
   input  entry_type        right_entry,
   input  cmd_kind_type     cmd_kind,
   input  logic [IDX_W-1:0] cmd_pos,
   input  entry_type        cmd_entry,
   output entry_type        entry
);

   localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
   localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(INDEX);

   entry_type        entry_ff, entry_in;
   token_type        tok_ff, tok_in_next;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in_next;
   logic [CNT_W-1:0] pos_ff, pos_in_next;
   logic             slot_valid;
   logic [LEN_W-1:0] entry_end;

   assign slot_valid = MY_CNT < count;
   assign entry_end  = LEN_W'({1'b0, entry_ff.start}) + entry_ff.length;

   // Table update: shifts take data from a neighbor, writes from the command.
   always_comb begin
      entry_in = entry_ff;
      unique case (cmd_kind)
         CMD_HOLD: begin
            entry_in = entry_ff;
         end
         CMD_WRITE: begin
            if (MY_IDX == cmd_pos) entry_in = cmd_entry;
         end
         CMD_INSERT: begin
            if (MY_IDX > cmd_pos) entry_in = left_entry;
            else if (MY_IDX == cmd_pos) entry_in = cmd_entry;
         end
         CMD_DELETE: begin
            if (MY_IDX >= cmd_pos) entry_in = right_entry;
         end
         default: entry_in = entry_ff;
      endcase
   end

   // Token stage: best-fit candidate and the insertion point for a free.
   always_comb begin
      tok_in_next      = tok_in;
      best_idx_in_next = best_idx_in;
      pos_in_next      = pos_in;
      if (slot_valid) begin
         if (entry_ff.length >= size &&
             (!tok_in.best_found || entry_ff.length < tok_in.best_len)) begin
            tok_in_next.best_found = 1'b1;
            tok_in_next.best_start = entry_ff.start;
            tok_in_next.best_len   = entry_ff.length;
            best_idx_in_next       = MY_IDX;
         end
         if (!tok_in.stopped) begin
            if (entry_ff.start <= offset) begin
               tok_in_next.has_prev   = 1'b1;
               tok_in_next.prev_start = entry_ff.start;
               tok_in_next.prev_end   = entry_end;
               pos_in_next            = MY_CNT + 1'b1;
            end else begin
               tok_in_next.stopped   = 1'b1;
               tok_in_next.nxt_start = entry_ff.start;
               tok_in_next.nxt_end   = entry_end;
            end
         end
      end
   end

   // Slot zero holds the whole pool after reset; other slots are unwritten.
   always_ff @(posedge clock) begin
      if (reset && INDEX == 0) begin
         entry_ff.start  <= '0;
         entry_ff.length <= LEN_W'(POOL_SIZE);
      end else begin
         entry_ff <= entry_in;
      end
      tok_ff      <= tok_in_next;
      best_idx_ff <= best_idx_in_next;
      pos_ff      <= pos_in_next;
   end

   assign entry        = entry_ff;
   assign tok_out      = tok_ff;
   assign best_idx_out = best_idx_ff;
   assign pos_out      = pos_ff;

endmodule

@@ rtl/best_fit_range_allocator_core.sv @@
// A request is captured in idle, then the search token walks the chain of
// MAX_FREE_RANGES cells, one cell a cycle, and the table is updated (with an extra
// merge step when a free merges with both neighbors) before the response is
// presented; one request is in flight at a time, and the next request is taken
// after the response transfer.
// Reset (synchronous) leaves one free range covering the whole pool.
module best_fit_range_allocator_core
   import bfra_pkg::*;
#(
   parameter int MAX_FREE_RANGES = 64,
   parameter int POOL_SIZE       = 134217728
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(MAX_FREE_RANGES + 1);
   localparam int IDX_W = $clog2(MAX_FREE_RANGES);
   localparam int LAST  = MAX_FREE_RANGES - 1;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] count_ff, count_in;
   req_type          req_ff, req_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0] del_pos_ff, del_pos_in;

   cmd_kind_type     cmd_kind;
   logic [IDX_W-1:0] cmd_pos;
   entry_type        cmd_entry;

   token_type        tok [MAX_FREE_RANGES];
   logic [IDX_W-1:0] bidx [MAX_FREE_RANGES];
   logic [CNT_W-1:0] pos [MAX_FREE_RANGES];
   entry_type        ent [MAX_FREE_RANGES];

   token_type        tok_init;
   token_type        fin;
   logic [CNT_W-1:0] fin_pos, fin_pos_m1;
   logic [OFF_W+1:0] free_end;
   logic             lt, rt;

   assign tok_init = '0;

   // Chain of table cells; the token enters cell zero and leaves the last one.
   for (genvar i = 0; i < MAX_FREE_RANGES; i++) begin : g_cell
      bfra_cell #(
         .INDEX          (i),
         .MAX_FREE_RANGES(MAX_FREE_RANGES),
         .POOL_SIZE      (POOL_SIZE),
         .CNT_W          (CNT_W),
         .IDX_W          (IDX_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .count       (count_ff),
         .size        (req_ff.req_size),
         .offset      (req_ff.req_offset),
         .tok_in      ((i == 0) ? tok_init : tok[(i == 0) ? 0 : i - 1]),
         .best_idx_in ((i == 0) ? '0 : bidx[(i == 0) ? 0 : i - 1]),
         .pos_in      ((i == 0) ? '0 : pos[(i == 0) ? 0 : i - 1]),
         .tok_out     (tok[i]),
         .best_idx_out(bidx[i]),
         .pos_out     (pos[i]),
         .left_entry  ((i == 0) ? cmd_entry : ent[(i == 0) ? 0 : i - 1]),
         .right_entry ((i == LAST) ? ent[i] : ent[(i == LAST) ? i : i + 1]),
         .cmd_kind    (cmd_kind),
         .cmd_pos     (cmd_pos),
         .cmd_entry   (cmd_entry),
         .entry       (ent[i])
      );
   end

   // Search results as they leave the chain.
   assign fin        = tok[LAST];
   assign fin_pos    = pos[LAST];
   assign fin_pos_m1 = fin_pos - 1'b1;
   assign free_end   = {2'b0, req_ff.req_offset} + {1'b0, req_ff.req_size};
   assign lt = fin.has_prev && fin.prev_end == {1'b0, req_ff.req_offset};
   assign rt = fin.stopped && {2'b0, fin.nxt_start} == free_end;

   // Sequencer: capture, scan, update the table, then present the response.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      count_in     = count_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      del_pos_in   = del_pos_ff;
      cmd_kind     = CMD_HOLD;
      cmd_pos      = '0;
      cmd_entry    = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cnt_ff == CNT_W'(MAX_FREE_RANGES)) begin
               rsp_in   = '0;
               state_in = ST_FINISH;
               if (req_ff.op == OP_ALLOC) begin
                  if (req_ff.req_size != '0 && fin.best_found) begin
                     rsp_in.alloc_offset = fin.best_start;
                     rsp_in.status       = STAT_OK;
                     cmd_pos             = bidx[LAST];
                     if (fin.best_len == req_ff.req_size) begin
                        cmd_kind = CMD_DELETE;
                        count_in = count_ff - 1'b1;
                     end else begin
                        cmd_kind         = CMD_WRITE;
                        cmd_entry.start  = OFF_W'({1'b0, fin.best_start} + req_ff.req_size);
                        cmd_entry.length = fin.best_len - req_ff.req_size;
                     end
                  end else begin
                     rsp_in.status = STAT_NO_FIT;
                  end
               end else if (req_ff.req_size == '0 ||
                            free_end > (OFF_W + 2)'(POOL_SIZE)) begin
                  rsp_in.status = STAT_OK;
               end else if (lt && rt) begin
                  // Bridge two ranges: widen the left one, then drop the right.
                  cmd_kind         = CMD_WRITE;
                  cmd_pos          = fin_pos_m1[IDX_W-1:0];
                  cmd_entry.start  = fin.prev_start;
                  cmd_entry.length = fin.nxt_end - LEN_W'(fin.prev_start);
                  del_pos_in       = fin_pos[IDX_W-1:0];
                  state_in         = ST_MERGE;
               end else if (lt) begin
                  cmd_kind         = CMD_WRITE;
                  cmd_pos          = fin_pos_m1[IDX_W-1:0];
                  cmd_entry.start  = fin.prev_start;
                  cmd_entry.length = LEN_W'(free_end) - LEN_W'(fin.prev_start);
               end else if (rt) begin
                  cmd_kind         = CMD_WRITE;
                  cmd_pos          = fin_pos[IDX_W-1:0];
                  cmd_entry.start  = req_ff.req_offset;
                  cmd_entry.length = fin.nxt_end - LEN_W'(req_ff.req_offset);
               end else if (count_ff >= CNT_W'(MAX_FREE_RANGES)) begin
                  rsp_in.status = STAT_FULL;
               end else begin
                  cmd_kind         = CMD_INSERT;
                  cmd_pos          = fin_pos[IDX_W-1:0];
                  cmd_entry.start  = req_ff.req_offset;
                  cmd_entry.length = req_ff.req_size;
                  count_in         = count_ff + 1'b1;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MERGE: begin
            cmd_kind = CMD_DELETE;
            cmd_pos  = del_pos_ff;
            count_in = count_ff - 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            rsp_in.pool_idle = req_ff.op == OP_FREE && count_ff == CNT_W'(1) &&
                               ent[0].start == '0 &&
                               ent[0].length == LEN_W'(POOL_SIZE);
            rsp_valid_in = 1'b1;
            state_in     = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state is set by reset; payload registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
      req_ff     <= req_in;
      rsp_ff     <= rsp_in;
      del_pos_ff <= del_pos_in;
   end

   assign req_stall = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
